/* sv/rau_pkg.sv */
// ----------------------------------------------------------------------------
// rau_pkg
// shared types, codes and widths of the rational arithmetic unit
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

    localparam int RAU_OPW_DEF = 32;
    localparam int MAG_W       = 32;
    localparam int PROD_W      = 2 * MAG_W;
    localparam int CNT_W       = 7;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_NEG = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_OVF      = 2'd2,
        ST_ZERO_GCD = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_GCD,
        S_DIV,
        S_CHK,
        S_OUT
    } t_state;

    // three products: two numerator terms and the denominator
    typedef struct packed {
        logic [2:0][MAG_W-1:0] x;
        logic [2:0][MAG_W-1:0] y;
        logic [2:0]            neg;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_qhead;

endpackage

`default_nettype wire

/* sv/rational_arith_unit.sv */
// ----------------------------------------------------------------------------
// rational_arith_unit
// exact add, subtract, multiply, divide and negate of two signed fractions,
// reduced by their greatest common divisor
// ----------------------------------------------------------------------------
// channel   dir  signals                       content
// s         in   i_s_tvalid/o_s_tready         tdata: a_num,a_den,b_num,b_den
//                                              tuser: req_type
// m         out  o_m_tvalid/i_m_tready         tdata: res_num,res_den
//                                              tuser: status
//
// one item passes through a pop, the three products, one sum, the binary gcd
// loop, a shift-subtract divide, one check and one output load; a zero gcd
// skips divide and check
// two items can wait in the input queue while the back end works
// reset clears queue, sequencer and output valid, synchronous active low
// a stalled output holds the back end only; the front keeps filling the queue
// ----------------------------------------------------------------------------
`default_nettype none

module rational_arith_unit import rau_pkg::*; #(
    parameter int OPERAND_WIDTH = RAU_OPW_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [127:0] i_s_tdata,   // a_num, a_den, b_num, b_den
    input  wire logic [2:0]   i_s_tuser,   // req_type
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [63:0]       o_m_tdata,   // res_num, res_den
    output logic [1:0]        o_m_tuser    // status
);

    t_qhead w_head;
    logic   w_pop;

    rau_front #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_head     (w_head),
        .i_pop      (w_pop)
    );

    rau_back #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

`default_nettype wire

/* sv/rau_front.sv */
// ----------------------------------------------------------------------------
// rau_front
// accepts a word, sign-extends operands, maps the operation onto three
// products and queues the job in a two-entry fifo
// ----------------------------------------------------------------------------
`default_nettype none

module rau_front import rau_pkg::*; #(
    parameter int OPERAND_WIDTH = RAU_OPW_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [127:0] i_s_tdata,
    input  wire logic [2:0]   i_s_tuser,
    output t_qhead            o_head,
    input  wire logic         i_pop
);

    function automatic logic [MAG_W:0] sgnmag(input logic [31:0] raw);
        logic [31:0] v;
        logic        s;
        s = raw[OPERAND_WIDTH-1];
        for (int i = 0; i < 32; i++) begin
            v[i] = (i < OPERAND_WIDTH) ? raw[i] : s;
        end
        return {s, (s ? (32'd0 - v) : v)};
    endfunction

    logic [MAG_W:0] w_an, w_ad, w_bn, w_bd, w_one;
    t_job           w_job;

    t_job       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push;

    assign w_an  = sgnmag(i_s_tdata[31:0]);
    assign w_ad  = sgnmag(i_s_tdata[63:32]);
    assign w_bn  = sgnmag(i_s_tdata[95:64]);
    assign w_bd  = sgnmag(i_s_tdata[127:96]);
    assign w_one = {1'b0, 32'd1};

    always_comb begin
        w_job = '0;
        unique case (i_s_tuser)
            OP_ADD: begin
                w_job.x[0] = w_bn[MAG_W-1:0]; w_job.y[0] = w_ad[MAG_W-1:0];
                w_job.neg[0] = w_bn[MAG_W] ^ w_ad[MAG_W];
                w_job.x[1] = w_bd[MAG_W-1:0]; w_job.y[1] = w_an[MAG_W-1:0];
                w_job.neg[1] = w_bd[MAG_W] ^ w_an[MAG_W];
                w_job.x[2] = w_bd[MAG_W-1:0]; w_job.y[2] = w_ad[MAG_W-1:0];
                w_job.neg[2] = w_bd[MAG_W] ^ w_ad[MAG_W];
            end
            OP_SUB: begin
                w_job.x[0] = w_bd[MAG_W-1:0]; w_job.y[0] = w_an[MAG_W-1:0];
                w_job.neg[0] = w_bd[MAG_W] ^ w_an[MAG_W];
                w_job.x[1] = w_bn[MAG_W-1:0]; w_job.y[1] = w_ad[MAG_W-1:0];
                w_job.neg[1] = ~(w_bn[MAG_W] ^ w_ad[MAG_W]);
                w_job.x[2] = w_bd[MAG_W-1:0]; w_job.y[2] = w_ad[MAG_W-1:0];
                w_job.neg[2] = w_bd[MAG_W] ^ w_ad[MAG_W];
            end
            OP_MUL: begin
                w_job.x[0] = w_an[MAG_W-1:0]; w_job.y[0] = w_bn[MAG_W-1:0];
                w_job.neg[0] = w_an[MAG_W] ^ w_bn[MAG_W];
                w_job.x[2] = w_ad[MAG_W-1:0]; w_job.y[2] = w_bd[MAG_W-1:0];
                w_job.neg[2] = w_ad[MAG_W] ^ w_bd[MAG_W];
            end
            OP_DIV: begin
                w_job.x[0] = w_an[MAG_W-1:0]; w_job.y[0] = w_bd[MAG_W-1:0];
                w_job.neg[0] = w_an[MAG_W] ^ w_bd[MAG_W];
                w_job.x[2] = w_ad[MAG_W-1:0]; w_job.y[2] = w_bn[MAG_W-1:0];
                w_job.neg[2] = w_ad[MAG_W] ^ w_bn[MAG_W];
            end
            default: begin
                // negate, also for undefined codes
                w_job.x[0] = w_an[MAG_W-1:0]; w_job.y[0] = w_one[MAG_W-1:0];
                w_job.neg[0] = ~w_an[MAG_W];
                w_job.x[2] = w_ad[MAG_W-1:0]; w_job.y[2] = w_one[MAG_W-1:0];
                w_job.neg[2] = w_ad[MAG_W];
            end
        endcase
    end

    assign o_s_tready   = (r_cnt != 2'd2);
    assign w_push       = i_s_tvalid && o_s_tready;
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.job   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_job;
        end
    end

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_cnt != 2'd0)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

/* sv/rau_back.sv */
// ----------------------------------------------------------------------------
// rau_back
// forms the exact products and sum, binary gcd, bit-serial division by the
// gcd, range check and the output register
// ----------------------------------------------------------------------------
`default_nettype none

module rau_back import rau_pkg::*; #(
    parameter int OPERAND_WIDTH = RAU_OPW_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_qhead      i_head,
    output logic             o_pop,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [63:0]      o_m_tdata,
    output logic [1:0]       o_m_tuser
);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt;
    t_job              r_job;
    logic [PROD_W-1:0] r_p [3];
    logic              r_nneg, r_dneg;
    logic [PROD_W-1:0] r_a, r_b, r_g, r_qn, r_qd, r_rn, r_rd;
    logic [CNT_W-1:0]  r_k;
    logic [31:0]       r_res_num, r_res_den;
    t_status           r_res_st;
    logic              r_ovalid;
    logic [63:0]       r_odata;
    t_status           r_ost;

    logic              w_gcd_end, w_load;
    logic [1:0]        w_idx;
    logic [PROD_W:0]   w_t0, w_t1, w_sum, w_tn, w_td;
    logic [PROD_W-1:0] w_lim;
    logic              w_fit_n, w_fit_d;

    assign w_idx     = r_cnt[1:0];
    assign w_gcd_end = (r_a == '0) || (r_b == '0);
    assign w_load    = (r_state == S_OUT) && (!r_ovalid || i_m_tready);

    assign w_t0  = r_job.neg[0] ? ((PROD_W+1)'(0) - {1'b0, r_p[0]}) : {1'b0, r_p[0]};
    assign w_t1  = r_job.neg[1] ? ((PROD_W+1)'(0) - {1'b0, r_p[1]}) : {1'b0, r_p[1]};
    assign w_sum = w_t0 + w_t1;

    assign w_tn = {r_rn, r_qn[PROD_W-1]};
    assign w_td = {r_rd, r_qd[PROD_W-1]};

    assign w_lim   = PROD_W'(1) << (OPERAND_WIDTH - 1);
    assign w_fit_n = r_nneg ? (r_qn <= w_lim) : (r_qn < w_lim);
    assign w_fit_d = r_dneg ? (r_qd <= w_lim) : (r_qd < w_lim);

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    o_pop   = 1'b1;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (w_idx == 2'd2) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: n_state = S_GCD;
            S_GCD: begin
                if (w_gcd_end) begin
                    n_state = ((r_a | r_b) == '0) ? S_OUT : S_DIV;
                end
            end
            S_DIV: begin
                if (r_cnt == CNT_W'(PROD_W - 1)) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: n_state = S_OUT;
            S_OUT: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_odata <= {r_res_den, r_res_num};
            r_ost   <= r_res_st;
        end
        case (r_state)
            S_IDLE: begin
                r_job <= i_head.job;
                r_cnt <= '0;
            end
            S_MUL: begin
                r_p[w_idx] <= PROD_W'(r_job.x[w_idx]) * PROD_W'(r_job.y[w_idx]);
                r_cnt      <= r_cnt + 1'b1;
            end
            S_SUM: begin
                r_nneg <= w_sum[PROD_W];
                r_a    <= w_sum[PROD_W] ? PROD_W'((PROD_W+1)'(0) - w_sum)
                                        : w_sum[PROD_W-1:0];
                r_qn   <= w_sum[PROD_W] ? PROD_W'((PROD_W+1)'(0) - w_sum)
                                        : w_sum[PROD_W-1:0];
                r_b    <= r_p[2];
                r_qd   <= r_p[2];
                r_dneg <= r_job.neg[2] && (r_p[2] != '0);
                r_k    <= '0;
            end
            S_GCD: begin
                if (w_gcd_end) begin
                    r_g       <= (r_a | r_b) << r_k;
                    r_cnt     <= '0;
                    r_rn      <= '0;
                    r_rd      <= '0;
                    r_res_num <= '0;
                    r_res_den <= '0;
                    r_res_st  <= ST_ZERO_GCD;
                end else if (!r_a[0] && !r_b[0]) begin
                    r_a <= r_a >> 1;
                    r_b <= r_b >> 1;
                    r_k <= r_k + 1'b1;
                end else if (!r_a[0]) begin
                    r_a <= r_a >> 1;
                end else if (!r_b[0]) begin
                    r_b <= r_b >> 1;
                end else if (r_a >= r_b) begin
                    r_a <= r_a - r_b;
                end else begin
                    r_b <= r_b - r_a;
                end
            end
            S_DIV: begin
                if (w_tn >= {1'b0, r_g}) begin
                    r_rn <= PROD_W'(w_tn - {1'b0, r_g});
                    r_qn <= {r_qn[PROD_W-2:0], 1'b1};
                end else begin
                    r_rn <= w_tn[PROD_W-1:0];
                    r_qn <= {r_qn[PROD_W-2:0], 1'b0};
                end
                if (w_td >= {1'b0, r_g}) begin
                    r_rd <= PROD_W'(w_td - {1'b0, r_g});
                    r_qd <= {r_qd[PROD_W-2:0], 1'b1};
                end else begin
                    r_rd <= w_td[PROD_W-1:0];
                    r_qd <= {r_qd[PROD_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
            end
            S_CHK: begin
                if (!w_fit_n || !w_fit_d) begin
                    r_res_num <= '0;
                    r_res_den <= '0;
                    r_res_st  <= ST_OVF;
                end else begin
                    r_res_num <= r_nneg ? (32'd0 - r_qn[31:0]) : r_qn[31:0];
                    r_res_den <= r_dneg ? (32'd0 - r_qd[31:0]) : r_qd[31:0];
                    r_res_st  <= (r_qd == '0) ? ST_ZERO_DEN : ST_OK;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ost;

    a_zero_gcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == ST_ZERO_GCD) |-> o_m_tdata == 64'd0)
        else $error("zero gcd result not cleared");

    a_zero_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == ST_ZERO_DEN) |->
        (o_m_tdata[63:32] == 32'd0 &&
         (o_m_tdata[31:0] == 32'd1 || o_m_tdata[31:0] == 32'hFFFF_FFFF)))
        else $error("zero denominator result not unit");

    a_div_gcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> r_g != '0)
        else $error("division by zero gcd");

endmodule

`default_nettype wire

/* bench/rational_arith_unit_checker.sv */
// ----------------------------------------------------------------------------
// rational_arith_unit_checker
// watches both stream channels of the rational arithmetic unit, predicts the
// reduced fraction and status of every accepted request and compares each
// result word in order
// ----------------------------------------------------------------------------
`default_nettype none

module rational_arith_unit_checker import rau_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    input  wire logic         i_s_tready,
    input  wire logic [127:0] i_s_tdata,   // a_num, a_den, b_num, b_den
    input  wire logic [2:0]   i_s_tuser,   // req_type
    input  wire logic         i_m_tvalid,
    input  wire logic         i_m_tready,
    input  wire logic [63:0]  i_m_tdata,   // res_num, res_den
    input  wire logic [1:0]   i_m_tuser,   // status
    output int                o_fail_cnt,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] num;
        logic [31:0] den;
        t_status     status;
    } t_fraction;

    t_fraction reduced_q[$];

    // signed value carried as sign and 64-bit magnitude
    function automatic logic [64:0] mul_sm(longint x, longint y);
        logic [63:0] mx, my, m;
        mx = x < 0 ? 64'(-x) : 64'(x);
        my = y < 0 ? 64'(-y) : 64'(y);
        m  = mx * my;
        return {(m != 0) && ((x < 0) != (y < 0)), m};
    endfunction

    function automatic logic [64:0] neg_sm(logic [64:0] v);
        return {(v[63:0] != 0) && !v[64], v[63:0]};
    endfunction

    function automatic logic [64:0] add_sm(logic [64:0] x, logic [64:0] y);
        logic [64:0] r;
        if (x[64] == y[64]) r = {x[64], x[63:0] + y[63:0]};
        else if (x[63:0] >= y[63:0]) r = {x[64], x[63:0] - y[63:0]};
        else r = {y[64], y[63:0] - x[63:0]};
        if (r[63:0] == 0) r[64] = 1'b0;
        return r;
    endfunction

    function automatic logic fits32(logic [64:0] v);
        return v[64] ? (v[63:0] <= 64'h8000_0000) : (v[63:0] < 64'h8000_0000);
    endfunction

    function automatic t_fraction reduce_fraction(logic [2:0] op, logic [127:0] d);
        longint an, ad, bn, bd;
        logic [64:0] num, den;
        logic [63:0] g, x, y, t;
        t_fraction r;
        an = longint'($signed(d[31:0]));
        ad = longint'($signed(d[63:32]));
        bn = longint'($signed(d[95:64]));
        bd = longint'($signed(d[127:96]));
        case (op)
            OP_ADD: begin
                num = add_sm(mul_sm(bn, ad), mul_sm(bd, an));
                den = mul_sm(bd, ad);
            end
            OP_SUB: begin
                num = add_sm(mul_sm(bd, an), neg_sm(mul_sm(bn, ad)));
                den = mul_sm(bd, ad);
            end
            OP_MUL: begin
                num = mul_sm(an, bn);
                den = mul_sm(ad, bd);
            end
            OP_DIV: begin
                num = mul_sm(an, bd);
                den = mul_sm(ad, bn);
            end
            default: begin
                num = neg_sm(mul_sm(an, 1));
                den = mul_sm(ad, 1);
            end
        endcase
        x = num[63:0];
        y = den[63:0];
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        g = x;
        r = '0;
        if (g == 0) begin
            r.status = ST_ZERO_GCD;
            return r;
        end
        num[63:0] = num[63:0] / g;
        den[63:0] = den[63:0] / g;
        if (!fits32(num) || !fits32(den)) begin
            r.status = ST_OVF;
            return r;
        end
        r.num    = num[64] ? 32'(-num[63:0]) : num[31:0];
        r.den    = den[64] ? 32'(-den[63:0]) : den[31:0];
        r.status = den[63:0] == 0 ? ST_ZERO_DEN : ST_OK;
        return r;
    endfunction

    assign o_pending = reduced_q.size();

    initial o_fail_cnt = 0;

    always @(posedge i_clk) begin
        t_fraction want;
        int        errs;
        errs = 0;
        if (i_rst_n && i_s_tvalid && i_s_tready)
            reduced_q.push_back(reduce_fraction(i_s_tuser, i_s_tdata));
        if (i_rst_n && i_m_tvalid && i_m_tready) begin
            if (reduced_q.size() == 0) begin
                $error("result word with no request waiting");
                errs++;
            end else begin
                want = reduced_q.pop_front();
                if (i_m_tdata[31:0] !== want.num) begin
                    $error("res_num expected %0d actual %0d",
                           $signed(want.num), $signed(i_m_tdata[31:0]));
                    errs++;
                end
                if (i_m_tdata[63:32] !== want.den) begin
                    $error("res_den expected %0d actual %0d",
                           $signed(want.den), $signed(i_m_tdata[63:32]));
                    errs++;
                end
                if (i_m_tuser !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, i_m_tuser);
                    errs++;
                end
            end
        end
        if (errs != 0)
            o_fail_cnt <= o_fail_cnt + errs;
    end

endmodule

`default_nettype wire

/* bench/rational_arith_unit_tb.sv */
// ----------------------------------------------------------------------------
// rational_arith_unit_tb
// directed corner requests and random fractions with random gaps on both
// channels; results are checked in order by the checker module
// ----------------------------------------------------------------------------
`default_nettype none

module rational_arith_unit_tb import rau_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [127:0] i_s_tdata = '0;   // a_num, a_den, b_num, b_den
    logic [2:0]   i_s_tuser = '0;   // req_type
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [63:0]  o_m_tdata;        // res_num, res_den
    logic [1:0]   o_m_tuser;        // status
    int           fail_cnt;
    int           pending;

    always #10 i_clk = ~i_clk;

    rational_arith_unit DUT (.*);

    rational_arith_unit_checker u_checker (
        .i_clk, .i_rst_n, .i_s_tvalid, .i_s_tready(o_s_tready), .i_s_tdata,
        .i_s_tuser, .i_m_tvalid(o_m_tvalid), .i_m_tready, .i_m_tdata(o_m_tdata),
        .i_m_tuser(o_m_tuser), .o_fail_cnt(fail_cnt), .o_pending(pending)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 400);
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 20) - 10;
            1: return {$urandom_range(0, 1) ? 24'hffffff : 24'h0, 8'($urandom)};
            2: return 32'h8000_0000 + $urandom_range(0, 2);
            3: return 32'h7fff_fffd + $urandom_range(0, 2);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
                             logic [31:0] bn, logic [31:0] bd);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {bd, bn, ad, an};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        int g;
        forever begin
            @(negedge i_clk);
            g = ($urandom_range(0, 99) < 30) ? gap_len() : 0;
            if (g > 0) begin
                i_m_tready <= 1'b0;
                repeat (g) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            repeat ($urandom_range(0, 30)) @(negedge i_clk);
        end
    end

    initial begin
        #200ms;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int n;
        logic [2:0] op;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // directed corners
        send_word(OP_ADD, 1, 2, 1, 3);
        send_word(OP_SUB, 1, 2, 1, 2);
        send_word(OP_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1);
        send_word(OP_DIV, 2, 3, 4, 5);
        send_word(OP_NEG, 32'h8000_0000, 1, 0, 0);
        send_word(OP_NEG, 32'h8000_0000, 32'h8000_0000, 0, 0);
        send_word(OP_ADD, 0, 0, 0, 0);
        send_word(OP_MUL, 5, 0, 3, 7);
        send_word(OP_DIV, 5, 1, 0, 1);
        send_word(OP_ADD, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1);
        send_word(OP_SUB, 32'h8000_0000, 1, 1, 1);
        send_word(OP_MUL, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                  32'h8000_0000);
        send_word(OP_ADD, -3, -4, 5, -6);
        send_word(3'd5, 7, -9, $urandom, $urandom);
        send_word(3'd6, 0, 3, 1, 1);
        send_word(3'd7, -6, 4, 1, 1);
        send_word(OP_DIV, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_word(OP_SUB, 0, 5, 0, -5);
        for (n = 0; n < 940; n++) begin
            op = $urandom_range(0, 9) < 9 ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
            send_word(op, rand_operand(), rand_operand(), rand_operand(), rand_operand());
        end
        i_s_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
